@@ design/pjd_pkg.sv @@
`timescale 1ns / 1ps
package pjd_pkg;

  localparam int QUEUE_DEPTH_DEF = 1024;
  localparam int WORKERS_DEF     = 8;
  localparam int TYPE_BITS_DEF   = 16;
  localparam int MASK_W          = 16;
  localparam int ENTRY_W         = 32;

  typedef enum logic [1:0] {
    CMD_SUBMIT = 2'd0,
    CMD_DONE   = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PRIO_LOW    = 2'd0,
    PRIO_NORMAL = 2'd1,
    PRIO_HIGH   = 2'd2
  } prio_e;

  typedef enum logic [2:0] {
    KIND_ASSIGNED  = 3'd0,
    KIND_QUEUED    = 3'd1,
    KIND_DROPPED   = 3'd2,
    KIND_FREED     = 3'd3,
    KIND_STEP_DONE = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    CFG_WORKER_COUNT = 2'd0,
    CFG_MASKS_LOW    = 2'd1,
    CFG_MASKS_HIGH   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    Q_HIGH   = 2'd0,
    Q_NORMAL = 2'd1,
    Q_LOW    = 2'd2
  } queue_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] job_id;
    logic [15:0] job_class;
    logic [1:0]  priority_req;
    logic [2:0]  worker_index;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  worker;
    logic [15:0] assigned_job;
    logic [15:0] assigned_type;
    logic [7:0]  busy_map;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  reg_index;
    logic [63:0] wdata;
  } cfg_item_t;

  typedef struct packed {
    logic       found;
    logic [2:0] idx;
  } match_t;

endpackage

@@ design/pjd_chan_if.sv @@
`timescale 1ns / 1ps
interface pjd_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/pjd_ram.sv @@
`timescale 1ns / 1ps
module pjd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/pjd_match.sv @@
`timescale 1ns / 1ps
module pjd_match
  import pjd_pkg::*;
#(
  parameter int WORKERS   = WORKERS_DEF,
  parameter int TYPE_BITS = TYPE_BITS_DEF
) (
  input  logic [15:0]               job_class_i,
  input  logic [WORKERS*MASK_W-1:0] masks_i,
  input  logic [WORKERS-1:0]        busy_i,
  input  logic [3:0]                active_i,
  output match_t                    match_o
);

  localparam logic [15:0] MATCH_BITS = 16'((17'd1 << TYPE_BITS) - 17'd1);

  logic [WORKERS-1:0] hit;

  always_comb begin
    for (int i = 0; i < WORKERS; i++) begin
      hit[i] = !busy_i[i] && (4'(i) < active_i) &&
               ((masks_i[i*MASK_W +: MASK_W] & job_class_i & MATCH_BITS) != 16'd0);
    end
  end

  // lowest index wins
  always_comb begin
    match_o = '0;
    for (int i = WORKERS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        match_o.found = 1'b1;
        match_o.idx   = 3'(i);
      end
    end
  end

endmodule

@@ design/priority_job_dispatcher_unit.sv @@
`timescale 1ns / 1ps
// Channel | Dir | Payload    | Transfer
// in_i    | in  | in_item_t  | valid && ready, ready while no command is in work
// out_o   | out | out_item_t | valid && ready, one output register
// cfg_i   | in  | cfg_item_t | valid && ready, ready always high
//
// Submit, done and unknown commands are accepted in S_IDLE and executed in S_EXEC.
// A tick walks the queues high, normal, low: S_READ skips an empty queue or reads its
// head from the queue RAM (registered read), S_EVAL assigns it to a free worker or moves
// on to the next queue, and the worker limit or the low queue ends it in S_FINISH.
// A full output register stalls execution until the result is taken.
// Reset clears pointers, counts and busy bits at once; queue RAM needs no clear.
module priority_job_dispatcher_unit
  import pjd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int WORKERS     = WORKERS_DEF,
  parameter int TYPE_BITS   = TYPE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pjd_chan_if.sink   in_i,
  pjd_chan_if.source out_o,
  pjd_chan_if.sink   cfg_i
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int KW = $clog2(WORKERS + 1);
  localparam int AW = PW + 2;
  localparam int RAM_DEPTH = 3 << PW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_EVAL,
    S_FINISH
  } state_e;

  state_e             state_q, state_d;
  in_item_t           item_q, item_d;
  queue_e             q_q, q_d;
  logic [KW-1:0]      k_q, k_d;
  logic [PW-1:0]      rd_ptr_q [3];
  logic [PW-1:0]      rd_ptr_d [3];
  logic [PW-1:0]      wr_ptr_q [3];
  logic [PW-1:0]      wr_ptr_d [3];
  logic [CW-1:0]      cnt_q [3];
  logic [CW-1:0]      cnt_d [3];
  logic [WORKERS-1:0] busy_q, busy_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_data_q, out_data_d;
  logic [3:0]         wc_q;
  logic [63:0]        masks_low_q, masks_high_q;

  logic               slot_free;
  logic               emit;
  logic               emit_assign;
  queue_e             tq;
  logic [7:0]         sel;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [15:0]        match_type;
  match_t             match;
  logic [3:0]         active;
  logic [127:0]       masks_all;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  assign active     = (wc_q > 4'(WORKERS)) ? 4'(WORKERS) : wc_q;
  assign masks_all  = {masks_high_q, masks_low_q};
  assign match_type = (state_q == S_EVAL) ? ram_rdata[31:16] : item_q.job_class;
  assign sel        = 8'd1 << match.idx;

  pjd_match #(
    .WORKERS   (WORKERS),
    .TYPE_BITS (TYPE_BITS)
  ) u_match (
    .job_class_i (match_type),
    .masks_i     (masks_all[WORKERS*MASK_W-1:0]),
    .busy_i      (busy_q),
    .active_i    (active),
    .match_o     (match)
  );

  pjd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({item_q.job_class, item_q.job_id}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  function automatic logic [WORKERS-1:0] sel_done(input logic [2:0] idx);
    logic [7:0] oh;
    oh = 8'd1 << idx;
    return oh[WORKERS-1:0];
  endfunction

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    q_d         = q_q;
    k_d         = k_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    cnt_d       = cnt_q;
    busy_d      = busy_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_o.ready;
    slot_free   = !out_valid_q || out_o.ready;
    emit        = 1'b0;
    emit_assign = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = '0;
    ram_raddr   = {2'(q_q), rd_ptr_q[q_q]};
    tq          = Q_NORMAL;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          item_d  = in_i.data;
          q_d     = Q_HIGH;
          k_d     = '0;
          state_d = (in_i.data.cmd == CMD_TICK) ? S_READ : S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          emit       = 1'b1;
          out_data_d = '0;
          out_data_d.last = 1'b1;
          state_d    = S_IDLE;
          case (item_q.cmd)
            CMD_SUBMIT: begin
              out_data_d.assigned_job  = item_q.job_id;
              out_data_d.assigned_type = item_q.job_class;
              if (item_q.priority_req == PRIO_HIGH && match.found) begin
                emit_assign       = 1'b1;
                busy_d            = busy_q | sel[WORKERS-1:0];
                out_data_d.kind   = KIND_ASSIGNED;
                out_data_d.worker = match.idx;
              end else begin
                if (item_q.priority_req == PRIO_HIGH) begin
                  tq = Q_HIGH;
                end else if (item_q.priority_req == PRIO_LOW) begin
                  tq = Q_LOW;
                end else begin
                  tq = Q_NORMAL;
                end
                if (cnt_q[tq] != CW'(QUEUE_DEPTH)) begin
                  ram_we       = 1'b1;
                  ram_waddr    = {2'(tq), wr_ptr_q[tq]};
                  wr_ptr_d[tq] = (wr_ptr_q[tq] == PW'(QUEUE_DEPTH - 1)) ? '0
                                 : wr_ptr_q[tq] + 1'b1;
                  cnt_d[tq]    = cnt_q[tq] + 1'b1;
                  out_data_d.kind = KIND_QUEUED;
                end else begin
                  out_data_d.kind = KIND_DROPPED;
                end
              end
            end
            CMD_DONE: begin
              busy_d            = busy_q & ~sel_done(item_q.worker_index);
              out_data_d.kind   = KIND_FREED;
              out_data_d.worker = item_q.worker_index;
            end
            default: begin
              out_data_d.kind = KIND_STEP_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        if (k_q == KW'(WORKERS)) begin
          state_d = S_FINISH;
        end else if (cnt_q[q_q] == '0) begin
          if (q_q == Q_LOW) begin
            state_d = S_FINISH;
          end else begin
            q_d = queue_e'(2'(q_q) + 2'd1);
          end
        end else begin
          ram_re  = 1'b1;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (match.found) begin
          if (slot_free) begin
            emit          = 1'b1;
            emit_assign   = 1'b1;
            busy_d        = busy_q | sel[WORKERS-1:0];
            rd_ptr_d[q_q] = (rd_ptr_q[q_q] == PW'(QUEUE_DEPTH - 1)) ? '0
                            : rd_ptr_q[q_q] + 1'b1;
            cnt_d[q_q]    = cnt_q[q_q] - 1'b1;
            k_d           = k_q + 1'b1;
            out_data_d               = '0;
            out_data_d.kind          = KIND_ASSIGNED;
            out_data_d.worker        = match.idx;
            out_data_d.assigned_job  = ram_rdata[15:0];
            out_data_d.assigned_type = ram_rdata[31:16];
            state_d       = S_READ;
          end
        end else if (q_q == Q_LOW) begin
          state_d = S_FINISH;
        end else begin
          q_d     = queue_e'(2'(q_q) + 2'd1);
          state_d = S_READ;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          emit            = 1'b1;
          out_data_d      = '0;
          out_data_d.kind = KIND_STEP_DONE;
          out_data_d.last = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_d         = 1'b1;
      out_data_d.busy_map = 8'(busy_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      q_q         <= Q_HIGH;
      k_q         <= '0;
      busy_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        rd_ptr_q[i] <= '0;
        wr_ptr_q[i] <= '0;
        cnt_q[i]    <= '0;
      end
    end else begin
      state_q     <= state_d;
      q_q         <= q_d;
      k_q         <= k_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q         <= 4'd8;
      masks_low_q  <= '1;
      masks_high_q <= '1;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.data.reg_index)
        CFG_WORKER_COUNT: wc_q         <= cfg_i.data.wdata[3:0];
        CFG_MASKS_LOW:    masks_low_q  <= cfg_i.data.wdata;
        CFG_MASKS_HIGH:   masks_high_q <= cfg_i.data.wdata;
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_rise_on_assign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q & ~$past(busy_q)) != '0 |-> $past(emit_assign))
    else $error("busy bit set without an assignment");

  a_eval_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EVAL |-> cnt_q[q_q] != '0)
    else $error("head read from an empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[0] <= CW'(QUEUE_DEPTH) && cnt_q[1] <= CW'(QUEUE_DEPTH) &&
    cnt_q[2] <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_tick_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= KW'(WORKERS))
    else $error("more assignments in one tick than workers");
`endif

endmodule
